FILE: rtl/bmcf_pkg.sv
// shared constants and elaboration-time helpers for the canonical form block
package bmcf_pkg;

    localparam int ROW_COUNT_DEF    = 7;
    localparam int COLUMN_COUNT_DEF = 5;
    localparam int NIBBLE_W         = 4;
    localparam int PERM_ENTRY_W     = 3;
    localparam int MAX_COLUMNS      = 6;
    localparam int PERM_VEC_W       = PERM_ENTRY_W * MAX_COLUMNS;

    function automatic int factorial(input int n);
        int f;
        f = 1;
        for (int i = 2; i <= n; i++)
        begin
            f = f * i;
        end
        return f;
    endfunction

    // lexicographic permutation number idx of n columns, entry c at bits 3c+:3
    function automatic logic [PERM_VEC_W-1:0] nth_perm(input int idx, input int n);
        logic [PERM_VEC_W-1:0] v;
        logic [MAX_COLUMNS-1:0] used;
        int rem;
        int f;
        int k;
        int seen;
        v    = '0;
        used = '0;
        rem  = idx;
        for (int pos = 0; pos < n; pos++)
        begin
            f = factorial(n - 1 - pos);
            k = 0;
            while (rem >= f)
            begin
                rem = rem - f;
                k   = k + 1;
            end
            seen = 0;
            for (int c = 0; c < n; c++)
            begin
                if (!used[c])
                begin
                    if (seen == k)
                    begin
                        v[PERM_ENTRY_W*pos +: PERM_ENTRY_W] = PERM_ENTRY_W'(c);
                        used[c] = 1'b1;
                    end
                    seen = seen + 1;
                end
            end
        end
        return v;
    endfunction

endpackage

FILE: rtl/bmcf_cell.sv
// one permutation cell: key of its column order, running minimum handed on
module bmcf_cell
    import bmcf_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
    parameter int PERM_INDEX   = 0
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ROW_COUNT*COLUMN_COUNT-1:0] in_matrix,
    input  logic [ROW_COUNT*COLUMN_COUNT-1:0] in_key,
    input  logic [NIBBLE_W*ROW_COUNT-1:0]     in_map,
    output logic                          out_valid,
    output logic [ROW_COUNT*COLUMN_COUNT-1:0] out_matrix,
    output logic [ROW_COUNT*COLUMN_COUNT-1:0] out_key,
    output logic [NIBBLE_W*ROW_COUNT-1:0]     out_map
);

    localparam int KEY_W  = ROW_COUNT * COLUMN_COUNT;
    localparam int MAP_W  = NIBBLE_W * ROW_COUNT;
    localparam int RANK_W = $clog2(ROW_COUNT);
    localparam logic [PERM_VEC_W-1:0] PERM = nth_perm(PERM_INDEX, COLUMN_COUNT);

    logic [COLUMN_COUNT-1:0] pat [ROW_COUNT];
    logic [RANK_W-1:0]       rank [ROW_COUNT];
    logic [KEY_W-1:0]        cand_key;
    logic [MAP_W-1:0]        cand_map;
    logic                    take;

    logic             valid_reg, valid_next;
    logic [KEY_W-1:0] matrix_reg, key_reg, key_next;
    logic [MAP_W-1:0] map_reg, map_next;

    always_comb
    begin
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            pat[r] = '0;
            for (int c = 0; c < COLUMN_COUNT; c++)
            begin
                pat[r][PERM[PERM_ENTRY_W*c +: PERM_ENTRY_W]] =
                    in_matrix[(ROW_COUNT-1-r)*COLUMN_COUNT + c];
            end
        end
        // sort position = rows ordered before this one
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            rank[r] = '0;
            for (int j = 0; j < ROW_COUNT; j++)
            begin
                if ((pat[j] < pat[r]) || ((pat[j] == pat[r]) && (j < r)))
                begin
                    rank[r] = rank[r] + RANK_W'(1);
                end
            end
        end
        cand_key = '0;
        cand_map = '0;
        for (int s = 0; s < ROW_COUNT; s++)
        begin
            for (int r = 0; r < ROW_COUNT; r++)
            begin
                if (rank[r] == RANK_W'(s))
                begin
                    cand_key[(ROW_COUNT-1-s)*COLUMN_COUNT +: COLUMN_COUNT] = pat[r];
                    cand_map[NIBBLE_W*s +: NIBBLE_W] = NIBBLE_W'(r);
                end
            end
        end
        take       = (PERM_INDEX == 0) || (cand_key < in_key);
        key_next   = take ? cand_key : in_key;
        map_next   = take ? cand_map : in_map;
        valid_next = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matrix_reg <= in_matrix;
        key_reg    <= key_next;
        map_reg    <= map_next;
    end

    assign out_valid  = valid_reg;
    assign out_matrix = matrix_reg;
    assign out_key    = key_reg;
    assign out_map    = map_reg;

endmodule

FILE: rtl/binary_matrix_canonical_form.sv
// top level: chain of permutation cells giving the column-permutation canonical form
// throughput: one matrix per cycle, each cell owns one column permutation
// the chain length is set by the permutation count, one registered cell per order
// busy is tied low; done pulses one cycle with the result and cannot be held off
// reset clears only the valid bits along the chain, payload is not reset
module binary_matrix_canonical_form
    import bmcf_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ROW_COUNT*COLUMN_COUNT-1:0] matrix_bits,
    output logic                              done,
    output logic [ROW_COUNT*COLUMN_COUNT-1:0] canonical_key,
    output logic [NIBBLE_W*ROW_COUNT-1:0]     row_origin_map
);

    localparam int KEY_W      = ROW_COUNT * COLUMN_COUNT;
    localparam int MAP_W      = NIBBLE_W * ROW_COUNT;
    localparam int PERM_COUNT = factorial(COLUMN_COUNT);

    // chain links: link 0 feeds the first cell, link PERM_COUNT is the result
    logic             link_valid  [PERM_COUNT+1];
    logic [KEY_W-1:0] link_matrix [PERM_COUNT+1];
    logic [KEY_W-1:0] link_key    [PERM_COUNT+1];
    logic [MAP_W-1:0] link_map    [PERM_COUNT+1];

    // every cycle is a free slot, so a start beat is always taken
    assign busy           = 1'b0;
    assign link_valid[0]  = start;
    assign link_matrix[0] = matrix_bits;
    assign link_key[0]    = '1;
    assign link_map[0]    = '0;

    // cell k tries permutation k in lexicographic order; strict less keeps the first tie
    for (genvar k = 0; k < PERM_COUNT; k++)
    begin : g_cell
        bmcf_cell #(
            .ROW_COUNT    (ROW_COUNT),
            .COLUMN_COUNT (COLUMN_COUNT),
            .PERM_INDEX   (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .in_valid   (link_valid[k]),
            .in_matrix  (link_matrix[k]),
            .in_key     (link_key[k]),
            .in_map     (link_map[k]),
            .out_valid  (link_valid[k+1]),
            .out_matrix (link_matrix[k+1]),
            .out_key    (link_key[k+1]),
            .out_map    (link_map[k+1])
        );
    end

    // result beat straight from the last cell's registers
    assign done           = link_valid[PERM_COUNT];
    assign canonical_key  = link_key[PERM_COUNT];
    assign row_origin_map = link_map[PERM_COUNT];

    // a start beat yields a result beat exactly one chain length later
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PERM_COUNT done)
        else $error("done does not track start by the chain length");

    // canonical rows come out sorted: row 0 never above row 1
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (canonical_key[KEY_W-1 -: COLUMN_COUNT]
                  <= canonical_key[KEY_W-1-COLUMN_COUNT -: COLUMN_COUNT]))
        else $error("canonical rows out of order");

    // the running minimum never grows through the last cell of the chain
    a_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[PERM_COUNT] |-> (link_key[PERM_COUNT] <= $past(link_key[PERM_COUNT-1])))
        else $error("running minimum increased in the last cell");

endmodule
